[rtl/srrw_pkg.sv]
// package for the selective-repeat receive window
// holds widths, window constants, result kinds and the shared sequence-unit types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  localparam int WINDOW_SLOTS = 32;
  localparam int MAX_PAYLOAD  = 512;

  localparam int SEQ_W    = 8;
  localparam int LEN_W    = 10;
  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int FREE_W   = 6;
  localparam int CNT_W    = 6;
  localparam int SLOT_W   = $clog2(WINDOW_SLOTS);

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_INC  = 2'd2,
    ALU_DEC  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   addr;
    logic [LEN_W-1:0]    length;
    logic [HANDLE_W-1:0] handle;
  } slot_wr_t;

endpackage

`default_nettype wire

[rtl/srrw_if.sv]
// valid/ready channel interfaces for the receive window
// packet-header input channel and result channel; depends on srrw_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srrw_in_if;
  import srrw_pkg::*;

  logic                valid;
  logic                ready;
  logic                is_data;
  logic [SEQ_W-1:0]    seq_number;
  logic                truncated;
  logic [LEN_W-1:0]    payload_length;
  logic [TIME_W-1:0]   sent_time;
  logic [HANDLE_W-1:0] payload_handle;

  modport source (output valid, is_data, seq_number, truncated, payload_length,
                  sent_time, payload_handle, input ready);
  modport sink (input valid, is_data, seq_number, truncated, payload_length,
                sent_time, payload_handle, output ready);
endinterface

interface srrw_out_if;
  import srrw_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [FREE_W-1:0]   free_window;
  logic [TIME_W-1:0]   echo_time;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_length;
  logic                last;

  modport source (output valid, kind, out_seq, free_window, echo_time, out_handle,
                  out_length, last, input ready);
  modport sink (input valid, kind, out_seq, free_window, echo_time, out_handle,
                out_length, last, output ready);
endinterface

`default_nettype wire

[rtl/srrw_alu.sv]
// shared sequence-number unit: difference, increment, decrement mod 256
// one adder reused by the check, increment and ack steps of the sequencer; depends on srrw_pkg
`timescale 1ns / 1ps
`default_nettype none

module srrw_alu (
  input  srrw_pkg::alu_req_t         req,
  output logic [srrw_pkg::SEQ_W-1:0] y
);
  import srrw_pkg::*;

  logic [SEQ_W-1:0] b_sel;
  logic             cin;

  always_comb begin
    case (req.op)
      ALU_SUB: begin
        b_sel = ~req.b;
        cin   = 1'b1;
      end
      ALU_INC: begin
        b_sel = '0;
        cin   = 1'b1;
      end
      ALU_DEC: begin
        b_sel = '1;
        cin   = 1'b0;
      end
      default: begin
        b_sel = '0;
        cin   = 1'b0;
      end
    endcase
  end

  assign y = req.a + b_sel + SEQ_W'(cin);

endmodule

`default_nettype wire

[rtl/srrw_slot_mem.sv]
// slot store for buffered out-of-order packets: length and payload handle
// one write port, one registered read port; depends on srrw_pkg
`timescale 1ns / 1ps
`default_nettype none

module srrw_slot_mem (
  input  logic                          clk,
  input  srrw_pkg::slot_wr_t            wr,
  input  logic [srrw_pkg::SLOT_W-1:0]   rd_addr,
  output logic [srrw_pkg::LEN_W-1:0]    rd_length,
  output logic [srrw_pkg::HANDLE_W-1:0] rd_handle
);
  import srrw_pkg::*;

  logic [LEN_W-1:0]    len_mem    [WINDOW_SLOTS];
  logic [HANDLE_W-1:0] handle_mem [WINDOW_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      len_mem[wr.addr]    <= wr.length;
      handle_mem[wr.addr] <= wr.handle;
    end
    rd_length <= len_mem[rd_addr];
    rd_handle <= handle_mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/selective_repeat_receive_window_top.sv]
// selective-repeat receive window: sequencer, slot valid flags and result register
// uses srrw_pkg, srrw_if, srrw_alu and srrw_slot_mem
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet header per transaction and answers with deliver, ack/nack or end
// results. A non-data header, or any header after the transfer ended, is taken and gives
// nothing. A packet that is stored, truncated or out of window goes through accept,
// window check and ack. An in-order packet is delivered at the window check, then drains
// the buffered packets behind it before ack: each drain step is one pass through the
// shared sequence adder plus one registered read of the slot memory. Results sit in one
// output register, so a stalled result sink holds the sequencer at its next result,
// while the next header can still be taken once the sequencer is back idle.
module selective_repeat_receive_window_top (
  input  logic      clk,
  input  logic      rst_n,
  srrw_in_if.sink   in_ch,
  srrw_out_if.source out_ch
);
  import srrw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INC,
    ST_PEEK,
    ST_ACK
  } state_t;

  state_t state_r, state_nxt;

  logic [SEQ_W-1:0]        expected_r, expected_nxt;
  logic [WINDOW_SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    finished_r, finished_nxt;

  // latched header
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic                tr_r, tr_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [SEQ_W-1:0]    oseq_r, oseq_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;
  logic [TIME_W-1:0]   echo_r, echo_nxt;
  logic [HANDLE_W-1:0] ohandle_r, ohandle_nxt;
  logic [LEN_W-1:0]    olen_r, olen_nxt;
  logic                last_r, last_nxt;

  alu_req_t          alu_req;
  logic [SEQ_W-1:0]  alu_y;
  slot_wr_t          mem_wr;
  logic [SLOT_W-1:0] rd_addr;
  logic [LEN_W-1:0]    rd_length;
  logic [HANDLE_W-1:0] rd_handle;

  logic              can_emit;
  logic [SLOT_W-1:0] seq_idx;
  logic [SLOT_W-1:0] exp_idx;
  logic [LEN_W-1:0]  len_clamped;

  srrw_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  srrw_slot_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_addr   (rd_addr),
    .rd_length (rd_length),
    .rd_handle (rd_handle)
  );

  assign can_emit    = !out_valid_r || out_ch.ready;
  assign seq_idx     = seq_r[SLOT_W-1:0];
  assign exp_idx     = expected_r[SLOT_W-1:0];
  assign len_clamped = (len_r > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : len_r;

  always_comb begin
    state_nxt     = state_r;
    expected_nxt  = expected_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    finished_nxt  = finished_r;
    seq_nxt       = seq_r;
    tr_nxt        = tr_r;
    len_nxt       = len_r;
    time_nxt      = time_r;
    handle_nxt    = handle_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    oseq_nxt      = oseq_r;
    free_nxt      = free_r;
    echo_nxt      = echo_r;
    ohandle_nxt   = ohandle_r;
    olen_nxt      = olen_r;
    last_nxt      = last_r;

    alu_req = '{op: ALU_PASS, a: expected_r, b: seq_r};
    mem_wr  = '{we: 1'b0, addr: seq_idx, length: len_clamped, handle: handle_r};
    rd_addr = exp_idx;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          seq_nxt    = in_ch.seq_number;
          tr_nxt     = in_ch.truncated;
          len_nxt    = in_ch.payload_length;
          time_nxt   = in_ch.sent_time;
          handle_nxt = in_ch.payload_handle;
          if (!finished_r && in_ch.is_data) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // alu gives the distance ahead of the expected number
        alu_req = '{op: ALU_SUB, a: seq_r, b: expected_r};
        if (len_r == '0 && alu_y == '0) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_END;
            oseq_nxt      = seq_r;
            free_nxt      = '0;
            echo_nxt      = '0;
            ohandle_nxt   = '0;
            olen_nxt      = '0;
            last_nxt      = 1'b1;
            finished_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (!tr_r && alu_y == '0) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_DELIVER;
            oseq_nxt      = seq_r;
            free_nxt      = '0;
            echo_nxt      = '0;
            ohandle_nxt   = handle_r;
            olen_nxt      = len_clamped;
            last_nxt      = 1'b0;
            state_nxt     = ST_INC;
          end
        end else if (!tr_r && alu_y < SEQ_W'(WINDOW_SLOTS)) begin
          mem_wr.we = 1'b1;
          if (!valid_r[seq_idx]) begin
            valid_nxt[seq_idx] = 1'b1;
            count_nxt          = count_r + CNT_W'(1);
          end
          state_nxt = ST_ACK;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_INC: begin
        alu_req      = '{op: ALU_INC, a: expected_r, b: seq_r};
        expected_nxt = alu_y;
        rd_addr      = alu_y[SLOT_W-1:0];
        state_nxt    = ST_PEEK;
      end
      ST_PEEK: begin
        // slot memory data for the new expected number is valid here
        if (valid_r[exp_idx]) begin
          if (can_emit) begin
            out_valid_nxt      = 1'b1;
            kind_nxt           = KIND_DELIVER;
            oseq_nxt           = expected_r;
            free_nxt           = '0;
            echo_nxt           = '0;
            ohandle_nxt        = rd_handle;
            olen_nxt           = rd_length;
            last_nxt           = 1'b0;
            valid_nxt[exp_idx] = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
            state_nxt = ST_INC;
          end
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        alu_req = '{op: (tr_r ? ALU_DEC : ALU_PASS), a: expected_r, b: seq_r};
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = tr_r ? KIND_NACK : KIND_ACK;
          oseq_nxt      = alu_y;
          free_nxt      = FREE_W'(WINDOW_SLOTS) - FREE_W'(count_r);
          echo_nxt      = time_r;
          ohandle_nxt   = '0;
          olen_nxt      = '0;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      expected_r  <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
    seq_r     <= seq_nxt;
    tr_r      <= tr_nxt;
    len_r     <= len_nxt;
    time_r    <= time_nxt;
    handle_r  <= handle_nxt;
    kind_r    <= kind_nxt;
    oseq_r    <= oseq_nxt;
    free_r    <= free_nxt;
    echo_r    <= echo_nxt;
    ohandle_r <= ohandle_nxt;
    olen_r    <= olen_nxt;
    last_r    <= last_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.out_seq     = oseq_r;
  assign out_ch.free_window = free_r;
  assign out_ch.echo_time   = echo_r;
  assign out_ch.out_handle  = ohandle_r;
  assign out_ch.out_length  = olen_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire

[verif/srrw_window_checker.sv]
`timescale 1ns / 1ps
// checker for the selective-repeat receive window: watches both channels, keeps its own
// copy of the window, predicts every result and compares it; depends on srrw_pkg, srrw_if

module srrw_window_checker
  import srrw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  srrw_in_if               hdr_mon,
  srrw_out_if              res_mon,
  output int               mismatches,
  output int               outstanding,
  output int               results_checked,
  output logic [SEQ_W-1:0] next_seq
);

  typedef struct packed {
    kind_t               kind;
    logic [SEQ_W-1:0]    seq;
    logic [FREE_W-1:0]   free_slots;
    logic [TIME_W-1:0]   echo;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic                last;
  } window_result_t;

  logic [SEQ_W-1:0]    want_seq;
  logic                slot_full [WINDOW_SLOTS];
  logic [LEN_W-1:0]    slot_len  [WINDOW_SLOTS];
  logic [HANDLE_W-1:0] slot_tag  [WINDOW_SLOTS];
  int                  held;
  bit                  ended;
  window_result_t      due_q[$];

  function automatic window_result_t make_result(kind_t k, logic [SEQ_W-1:0] s,
                                                 logic [FREE_W-1:0] f, logic [TIME_W-1:0] e,
                                                 logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] l,
                                                 logic fin);
    window_result_t r;
    r.kind = k;
    r.seq = s;
    r.free_slots = f;
    r.echo = e;
    r.handle = h;
    r.length = l;
    r.last = fin;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_length(logic [LEN_W-1:0] l);
    return (l > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : l;
  endfunction

  function automatic string show(window_result_t r);
    return $sformatf("kind %0d seq %0d free %0d echo %h handle %h len %0d last %0d",
                     r.kind, r.seq, r.free_slots, r.echo, r.handle, r.length, r.last);
  endfunction

  task automatic take_header();
    logic [SEQ_W-1:0]  ahead;
    logic [SLOT_W-1:0] idx;
    logic [FREE_W-1:0] free_now;
    int                n;
    if (ended || !hdr_mon.is_data) return;
    if (hdr_mon.payload_length == 0 && hdr_mon.seq_number == want_seq) begin
      ended = 1'b1;
      due_q.push_back(make_result(KIND_END, want_seq, '0, '0, '0, '0, 1'b1));
      return;
    end
    ahead = hdr_mon.seq_number - want_seq;
    if (!hdr_mon.truncated && ahead == 0) begin
      due_q.push_back(make_result(KIND_DELIVER, want_seq, '0, '0, hdr_mon.payload_handle,
                                  clamp_length(hdr_mon.payload_length), 1'b0));
      want_seq = want_seq + 1'b1;
      // drain consecutive buffered slots behind the in-order packet
      for (n = 0; n < WINDOW_SLOTS; n++) begin
        idx = want_seq[SLOT_W-1:0];
        if (!slot_full[idx]) break;
        due_q.push_back(make_result(KIND_DELIVER, want_seq, '0, '0, slot_tag[idx],
                                    slot_len[idx], 1'b0));
        slot_full[idx] = 1'b0;
        if (held > 0) held--;
        want_seq = want_seq + 1'b1;
      end
    end else if (!hdr_mon.truncated && ahead < WINDOW_SLOTS) begin
      idx = hdr_mon.seq_number[SLOT_W-1:0];
      if (!slot_full[idx]) begin
        slot_full[idx] = 1'b1;
        held++;
      end
      slot_len[idx] = clamp_length(hdr_mon.payload_length);
      slot_tag[idx] = hdr_mon.payload_handle;
    end
    free_now = (held >= WINDOW_SLOTS) ? '0 : FREE_W'(WINDOW_SLOTS - held);
    if (!hdr_mon.truncated)
      due_q.push_back(make_result(KIND_ACK, want_seq, free_now, hdr_mon.sent_time,
                                  '0, '0, 1'b1));
    else
      due_q.push_back(make_result(KIND_NACK, SEQ_W'(want_seq - 1'b1), free_now,
                                  hdr_mon.sent_time, '0, '0, 1'b1));
  endtask

  task automatic take_result();
    window_result_t got;
    window_result_t want;
    got = make_result(kind_t'(res_mon.kind), res_mon.out_seq, res_mon.free_window,
                      res_mon.echo_time, res_mon.out_handle, res_mon.out_length,
                      res_mon.last);
    results_checked++;
    if (due_q.size() == 0) begin
      if (mismatches < 10) $display("unexpected result: %s", show(got));
      mismatches++;
      return;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_seq = '0;
      held = 0;
      ended = 1'b0;
      due_q.delete();
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        slot_full[i] = 1'b0;
        slot_len[i] = '0;
        slot_tag[i] = '0;
      end
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (hdr_mon.valid && hdr_mon.ready) take_header();
      if (res_mon.valid && res_mon.ready) take_result();
    end
    outstanding <= due_q.size();
    next_seq <= want_seq;
  end

endmodule

[verif/selective_repeat_receive_window_top_test.sv]
`timescale 1ns / 1ps
// testbench top for the selective-repeat receive window: clock, reset, header stimulus,
// result-side stalls and the verdict; depends on srrw_pkg, srrw_if and srrw_window_checker

module selective_repeat_receive_window_top_test;
  import srrw_pkg::*;

  localparam int RANDOM_HEADERS = 90;
  localparam int SETTLE_CYCLES  = 80;

  typedef struct packed {
    logic                is_data;
    logic [SEQ_W-1:0]    seq;
    logic                truncated;
    logic [LEN_W-1:0]    len;
    logic [TIME_W-1:0]   stamp;
    logic [HANDLE_W-1:0] handle;
  } header_t;

  typedef enum int {NOISE_OTHER_TYPE, NOISE_TRUNCATED, NOISE_FAR, NOISE_OLD} noise_t;

  logic             clk = 1'b0;
  logic             rst_n;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               data_sent = 0;
  int               rand_start;
  int               burst_no;
  int               burst_len;
  bit               base_last;
  logic [SEQ_W-1:0] base;

  int               mismatches;
  int               outstanding;
  int               results_checked;
  logic [SEQ_W-1:0] next_seq;

  srrw_in_if  hdr_ch ();
  srrw_out_if res_ch ();

  selective_repeat_receive_window_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (hdr_ch),
    .out_ch (res_ch)
  );

  srrw_window_checker window_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .hdr_mon         (hdr_ch),
    .res_mon         (res_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .next_seq        (next_seq)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("selective_repeat_receive_window_top_test failed");
    $finish;
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic header_t hdr(logic d, logic [SEQ_W-1:0] s, logic t, logic [LEN_W-1:0] l,
                                  logic [TIME_W-1:0] st, logic [HANDLE_W-1:0] tag);
    header_t h;
    h.is_data = d;
    h.seq = s;
    h.truncated = t;
    h.len = l;
    h.stamp = st;
    h.handle = tag;
    return h;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length(bit zero_ok);
    int unsigned r;
    r = $urandom_range(9);
    if (zero_ok && r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(1023, MAX_PAYLOAD + 1));
    if (r == 2) return LEN_W'(MAX_PAYLOAD);
    return LEN_W'($urandom_range(MAX_PAYLOAD - 1, 1));
  endfunction

  function automatic header_t data_header(logic [SEQ_W-1:0] s, logic t, bit zero_ok);
    return hdr(1'b1, s, t, pick_length(zero_ok), $urandom, HANDLE_W'($urandom_range(65535)));
  endfunction

  // traffic that never lands in the window: other packet types, truncated copies,
  // packets far ahead and stale retransmissions
  function automatic header_t noise_header(logic [SEQ_W-1:0] b, int span);
    header_t h;
    noise_t  pick;
    h = data_header(b, 1'b0, 1'b0);
    pick = noise_t'($urandom_range(3));
    case (pick)
      NOISE_OTHER_TYPE: begin
        h.is_data = 1'b0;
        h.seq = SEQ_W'($urandom_range(255));
        h.truncated = 1'($urandom_range(1));
        h.len = LEN_W'($urandom_range(1023));
      end
      NOISE_TRUNCATED: begin
        h.truncated = 1'b1;
        h.seq = b + SEQ_W'($urandom_range(span + 3));
      end
      NOISE_FAR: h.seq = b + SEQ_W'($urandom_range(127, 40));
      default:   h.seq = b + SEQ_W'($urandom_range(255, 136));
    endcase
    return h;
  endfunction

  task automatic send_header(input header_t h);
    while ($urandom_range(99) < idle_pct) begin
      hdr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hdr_ch.valid <= 1'b1;
    hdr_ch.is_data <= h.is_data;
    hdr_ch.seq_number <= h.seq;
    hdr_ch.truncated <= h.truncated;
    hdr_ch.payload_length <= h.len;
    hdr_ch.sent_time <= h.stamp;
    hdr_ch.payload_handle <= h.handle;
    @(posedge clk);
    while (!hdr_ch.ready) @(posedge clk);
    if (h.is_data) data_sent++;
  endtask

  task automatic wait_idle();
    hdr_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(int p);
    case (p)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 71; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 71; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // one sender window: every number in [base, base+n) goes out untruncated at least once;
  // with base_last the in-order packet comes after all others, so it drains the whole run
  task automatic run_burst(input int n, input bit hold_base);
    int          order[$];
    int          pick;
    int          tmp;
    bit          zero_ok;
    logic [SEQ_W-1:0] s;
    for (int i = 1; i < n; i++) order.push_back(i);
    if (!hold_base) order.push_back(0);
    for (int i = order.size() - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    if (hold_base) order.push_back(0);
    foreach (order[k]) begin
      set_phase((data_sent - rand_start) * 4 / RANDOM_HEADERS);
      s = base + SEQ_W'(order[k]);
      // a zero length is only safe while it cannot be the expected number
      zero_ok = hold_base && order[k] != 0;
      if ($urandom_range(4) == 0) send_header(noise_header(base, n));
      if ($urandom_range(3) == 0) send_header(data_header(s, 1'b1, zero_ok));
      send_header(data_header(s, 1'b0, zero_ok));
      if ($urandom_range(7) == 0) send_header(data_header(s, 1'b0, zero_ok));
    end
    base = base + SEQ_W'(n);
  endtask

  initial begin
    rst_n <= 1'b0;
    hdr_ch.valid <= 1'b0;
    hdr_ch.is_data <= 1'b0;
    hdr_ch.seq_number <= '0;
    hdr_ch.truncated <= 1'b0;
    hdr_ch.payload_length <= '0;
    hdr_ch.sent_time <= '0;
    hdr_ch.payload_handle <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored types, nack before anything, old and edge-of-window packets,
    // overwrite, clamping, drains with zero-length slots
    send_header(hdr(1'b0, 8'd0,   1'b1, 10'd0,    32'hFFFF_FFFF, 16'hFFFF));
    send_header(hdr(1'b1, 8'd0,   1'b1, 10'd5,    32'h0000_0000, 16'h0000));
    send_header(hdr(1'b1, 8'd255, 1'b0, 10'd1,    32'h0000_0001, 16'h0001));
    send_header(hdr(1'b1, 8'd32,  1'b0, 10'd1,    32'h8000_0000, 16'h8000));
    send_header(hdr(1'b1, 8'd31,  1'b0, 10'd0,    32'h1234_5678, 16'h5A5A));
    send_header(hdr(1'b1, 8'd1,   1'b0, 10'd1023, 32'h0F0F_0F0F, 16'hFFFF));
    send_header(hdr(1'b1, 8'd1,   1'b0, 10'd9,    32'hF0F0_F0F0, 16'h1234));
    send_header(hdr(1'b1, 8'd2,   1'b1, 10'd1023, 32'h5555_5555, 16'hAAAA));
    send_header(hdr(1'b1, 8'd0,   1'b0, 10'd512,  32'hFFFF_FFFF, 16'hFFFF));
    send_header(hdr(1'b0, 8'd2,   1'b0, 10'd0,    32'h0000_0000, 16'h0000));
    send_header(hdr(1'b1, 8'd2,   1'b0, 10'd1,    32'h0000_0000, 16'h0000));
    send_header(hdr(1'b1, 8'd4,   1'b0, 10'd0,    32'hAAAA_AAAA, 16'h0F0F));
    send_header(hdr(1'b1, 8'd3,   1'b0, 10'd1023, 32'hA5A5_A5A5, 16'hC3C3));
    send_header(hdr(1'b1, 8'd200, 1'b1, 10'd0,    32'h7FFF_FFFF, 16'h7FFF));

    rand_start = data_sent;
    burst_no = 0;
    base = '0;
    while (data_sent - rand_start < RANDOM_HEADERS) begin
      set_phase((data_sent - rand_start) * 4 / RANDOM_HEADERS);
      burst_len = (burst_no == 3) ? WINDOW_SLOTS : $urandom_range(8, 1);
      base_last = (burst_no == 3) || ($urandom_range(1) == 1);
      if (base_last || burst_no == 0) begin
        wait_idle();
        base = next_seq;
      end
      run_burst(burst_len, base_last);
      burst_no++;
    end

    // end of transfer, then headers that must be ignored
    wait_idle();
    send_header(hdr(1'b1, next_seq, 1'(($urandom_range(1))), 10'd0, $urandom, 16'h00FF));
    send_header(hdr(1'b1, next_seq, 1'b0, 10'd100, $urandom, 16'h0100));
    send_header(hdr(1'b1, next_seq + 8'd1, 1'b0, 10'd7, $urandom, 16'h0200));
    send_header(hdr(1'b0, next_seq, 1'b0, 10'd0, $urandom, 16'h0300));
    wait_idle();

    $display("covered %0d data headers in %0d sender windows under four pacing phases,",
             data_sent, burst_no);
    $display("a full-window drain and the end of transfer; %0d results checked, %0d bad",
             results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("selective_repeat_receive_window_top_test passed");
    end else begin
      $display("selective_repeat_receive_window_top_test failed");
    end
    $finish;
  end

endmodule
